[rtl/euler_to_rotation_matrix_core_macros.svh]
// Assertion helpers used by the top RTL file of the rotation matrix block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define E2R_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("e2r: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define E2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("e2r: next-cycle check failed");

`endif

[rtl/e2r_pkg.sv]
`default_nettype none

package e2r_pkg;

  // Number formats.
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int ANG_W           = 16;
  localparam int OUT_W           = 16;

  // Angle limits in input units.
  localparam int ANG_LIM = 180 << ANGLE_FRAC_BITS;
  localparam int QUAD    = 90 << ANGLE_FRAC_BITS;
  localparam int OCTANT  = 45 << ANGLE_FRAC_BITS;
  localparam int OCT_W   = 16;

  // Degree to radian conversion, round(pi / 180 * 2^36).
  localparam logic [30:0] DEG_TO_RAD_Q36 = 31'd1199381129;
  localparam int          XSHIFT         = 6 + ANGLE_FRAC_BITS;

  // Q2.30 datapath widths.
  localparam int          X_W     = 30;
  localparam int          TERM_W  = 31;
  localparam int          SUM_W   = 33;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Output rounding.
  localparam int          OUT_SHIFT = 30 - OUT_FRAC_BITS;
  localparam logic [32:0] OUT_HALF  = (OUT_SHIFT > 0) ? (33'd1 << (OUT_SHIFT - 1)) : 33'd0;
  localparam logic [32:0] OUT_LIM   = 33'd1 << OUT_FRAC_BITS;

  // Lanes of the series chain.
  localparam int NUM_LANES  = 3;
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_ROLL  = 2;

  // Series cells: cell k forms cosine term 2k+2 and sine term 2k+3.
  localparam int NUM_CELLS = 6;
  localparam logic [7:0] COS_DIV [NUM_CELLS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [31:0] COS_RECIP [NUM_CELLS] = '{
    32'd2147483648, 32'd357913941, 32'd143165576,
    32'd76695844, 32'd47721858, 32'd32537631
  };
  // A zero divisor marks a cell without a sine term.
  localparam logic [7:0] SIN_DIV [NUM_CELLS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd0};
  localparam logic [31:0] SIN_RECIP [NUM_CELLS] = '{
    32'd715827882, 32'd214748364, 32'd102261126,
    32'd59652323, 32'd39045157, 32'd0
  };

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } out_item_t;

  // How the octant result maps back to the full angle.
  typedef struct packed {
    logic swap;
    logic cneg;
    logic sneg;
  } fold_t;

  typedef struct packed {
    logic [X_W-1:0]          x2;
    logic [TERM_W-1:0]       s_term;
    logic signed [SUM_W-1:0] s_sum;
    logic [TERM_W-1:0]       c_term;
    logic signed [SUM_W-1:0] c_sum;
    fold_t                   fold;
  } lane_t;

  typedef struct packed {
    logic                       valid;
    lane_t [NUM_LANES-1:0]      lane;
  } chain_t;

  typedef struct packed {
    logic        neg;
    logic        sin_act;
    logic [7:0]  sin_div;
    logic [31:0] sin_recip;
    logic [7:0]  cos_div;
    logic [31:0] cos_recip;
  } cell_cfg_t;

endpackage

`default_nettype wire

[rtl/e2r_front.sv]
`default_nettype none

module e2r_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              in_valid_i,
  input  e2r_pkg::in_item_t      in_item_i,
  output e2r_pkg::chain_t        chain_o
);
  import e2r_pkg::*;

  typedef struct packed {
    fold_t            fold;
    logic [OCT_W-1:0] oct;
  } octant_t;

  // Clamp to plus or minus 180 degrees and fold into the first octant.
  function automatic octant_t fold_angle(input logic signed [ANG_W-1:0] a);
    int      av;
    int      m;
    octant_t o;
    av = int'(a);
    if (av > ANG_LIM) av = ANG_LIM;
    if (av < -ANG_LIM) av = -ANG_LIM;
    o.fold.sneg = (av < 0);
    m = (av < 0) ? -av : av;
    if (m <= OCTANT) begin
      o.oct = OCT_W'(m);
      o.fold.swap = 1'b0;
      o.fold.cneg = 1'b0;
    end else if (m <= QUAD) begin
      o.oct = OCT_W'(QUAD - m);
      o.fold.swap = 1'b1;
      o.fold.cneg = 1'b0;
    end else if (m <= QUAD + OCTANT) begin
      o.oct = OCT_W'(m - QUAD);
      o.fold.swap = 1'b1;
      o.fold.cneg = 1'b1;
    end else begin
      o.oct = OCT_W'(2 * QUAD - m);
      o.fold.swap = 1'b0;
      o.fold.cneg = 1'b1;
    end
    return o;
  endfunction

  logic                  v0_q, v1_q, v2_q;
  octant_t               oct_q  [NUM_LANES];
  fold_t                 fold_q [NUM_LANES];
  logic [X_W-1:0]        x_q    [NUM_LANES];
  lane_t [NUM_LANES-1:0] lane_q;

  octant_t               oct_d  [NUM_LANES];
  logic [X_W-1:0]        x_d    [NUM_LANES];
  lane_t [NUM_LANES-1:0] lane_d;

  // Stage 0: fold each angle.
  always_comb begin
    oct_d[LANE_PITCH] = fold_angle(in_item_i.pitch_angle);
    oct_d[LANE_YAW]   = fold_angle(in_item_i.yaw_angle);
    oct_d[LANE_ROLL]  = fold_angle(in_item_i.roll_angle);
  end

  // Stage 1: convert the octant angle to Q2.30 radians.
  always_comb begin
    logic [47:0] xp;
    for (int i = 0; i < NUM_LANES; i++) begin
      xp = 48'(oct_q[i].oct) * 48'(DEG_TO_RAD_Q36) + (48'd1 << (XSHIFT - 1));
      x_d[i] = xp[XSHIFT+X_W-1:XSHIFT];
    end
  end

  // Stage 2: square the angle and seed both series.
  always_comb begin
    logic [59:0] sq;
    for (int i = 0; i < NUM_LANES; i++) begin
      sq = 60'(x_q[i]) * 60'(x_q[i]);
      lane_d[i].x2     = sq[59:30];
      lane_d[i].s_term = TERM_W'(x_q[i]);
      lane_d[i].s_sum  = $signed(SUM_W'(x_q[i]));
      lane_d[i].c_term = ONE_Q30;
      lane_d[i].c_sum  = $signed(SUM_W'(ONE_Q30));
      lane_d[i].fold   = fold_q[i];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        oct_q[i]  <= oct_d[i];
        x_q[i]    <= x_d[i];
        fold_q[i] <= oct_q[i].fold;
      end
      lane_q <= lane_d;
    end
  end

  assign chain_o.valid = v2_q;
  assign chain_o.lane  = lane_q;

endmodule

`default_nettype wire

[rtl/e2r_cell.sv]
`default_nettype none

module e2r_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  e2r_pkg::cell_cfg_t  cfg_i,
  input  e2r_pkg::chain_t     chain_i,
  output e2r_pkg::chain_t     chain_o
);
  import e2r_pkg::*;

  logic                  a_valid_q, b_valid_q, c_valid_q;
  lane_t [NUM_LANES-1:0] a_lane_q, b_lane_q, c_lane_q;
  logic [X_W-1:0]        va_s_q [NUM_LANES];
  logic [X_W-1:0]        va_c_q [NUM_LANES];
  logic [X_W-1:0]        vb_s_q [NUM_LANES];
  logic [X_W-1:0]        vb_c_q [NUM_LANES];
  logic [X_W-1:0]        qe_s_q [NUM_LANES];
  logic [X_W-1:0]        qe_c_q [NUM_LANES];

  logic [X_W-1:0]        va_s_d [NUM_LANES];
  logic [X_W-1:0]        va_c_d [NUM_LANES];
  logic [X_W-1:0]        qe_s_d [NUM_LANES];
  logic [X_W-1:0]        qe_c_d [NUM_LANES];
  lane_t [NUM_LANES-1:0] c_lane_d;

  // Exact floor division: the reciprocal estimate is low by at most one.
  function automatic logic [X_W-1:0] fix_quot(input logic [X_W-1:0] v,
                                              input logic [X_W-1:0] qe,
                                              input logic [7:0]     d);
    logic [37:0] qd;
    logic [37:0] rr;
    qd = 38'(qe) * 38'(d);
    rr = 38'(v) - qd;
    return (rr >= 38'(d)) ? qe + X_W'(1) : qe;
  endfunction

  // Stage a: previous term times x squared.
  always_comb begin
    logic [60:0] ps;
    logic [60:0] pc;
    for (int i = 0; i < NUM_LANES; i++) begin
      ps = 61'(chain_i.lane[i].s_term) * 61'(chain_i.lane[i].x2);
      pc = 61'(chain_i.lane[i].c_term) * 61'(chain_i.lane[i].x2);
      va_s_d[i] = ps[59:30];
      va_c_d[i] = pc[59:30];
    end
  end

  // Stage b: quotient estimate by reciprocal.
  always_comb begin
    logic [61:0] rs;
    logic [61:0] rc;
    for (int i = 0; i < NUM_LANES; i++) begin
      rs = 62'(va_s_q[i]) * 62'(cfg_i.sin_recip);
      rc = 62'(va_c_q[i]) * 62'(cfg_i.cos_recip);
      qe_s_d[i] = rs[61:32];
      qe_c_d[i] = rc[61:32];
    end
  end

  // Stage c: correct the quotient and accumulate with alternating sign.
  always_comb begin
    logic [X_W-1:0] qs;
    logic [X_W-1:0] qc;
    for (int i = 0; i < NUM_LANES; i++) begin
      c_lane_d[i] = b_lane_q[i];
      qs = fix_quot(vb_s_q[i], qe_s_q[i], cfg_i.sin_div);
      qc = fix_quot(vb_c_q[i], qe_c_q[i], cfg_i.cos_div);
      c_lane_d[i].c_term = TERM_W'(qc);
      c_lane_d[i].c_sum  = cfg_i.neg ? b_lane_q[i].c_sum - $signed(SUM_W'(qc))
                                     : b_lane_q[i].c_sum + $signed(SUM_W'(qc));
      if (cfg_i.sin_act) begin
        c_lane_d[i].s_term = TERM_W'(qs);
        c_lane_d[i].s_sum  = cfg_i.neg ? b_lane_q[i].s_sum - $signed(SUM_W'(qs))
                                       : b_lane_q[i].s_sum + $signed(SUM_W'(qs));
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= chain_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_lane_q <= chain_i.lane;
      b_lane_q <= a_lane_q;
      c_lane_q <= c_lane_d;
      for (int i = 0; i < NUM_LANES; i++) begin
        va_s_q[i] <= va_s_d[i];
        va_c_q[i] <= va_c_d[i];
        vb_s_q[i] <= va_s_q[i];
        vb_c_q[i] <= va_c_q[i];
        qe_s_q[i] <= qe_s_d[i];
        qe_c_q[i] <= qe_c_d[i];
      end
    end
  end

  assign chain_o.valid = c_valid_q;
  assign chain_o.lane  = c_lane_q;

endmodule

`default_nettype wire

[rtl/e2r_matrix.sv]
`default_nettype none

module e2r_matrix (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  e2r_pkg::chain_t      chain_i,
  output logic                 valid_o,
  output e2r_pkg::out_item_t   item_o
);
  import e2r_pkg::*;

  // Sign and magnitude of a Q2.30 value.
  typedef struct packed {
    logic        sg;
    logic [30:0] mag;
  } sm_t;

  localparam int NUM_PAIRS = 8;
  localparam int P_CYCR = 0;
  localparam int P_CPSR = 1;
  localparam int P_SYCR = 2;
  localparam int P_CYSR = 3;
  localparam int P_CPCR = 4;
  localparam int P_SYSR = 5;
  localparam int P_SYCP = 6;
  localparam int P_CYCP = 7;
  localparam int NUM_ELEMS = 9;

  // Q2.30 product, rounded to nearest with ties away from zero.
  function automatic sm_t qmul(input sm_t a, input sm_t b);
    logic [61:0] p;
    sm_t         r;
    p = 62'(a.mag) * 62'(b.mag) + (62'd1 << 29);
    r.mag = p[60:30];
    r.sg  = a.sg ^ b.sg;
    return r;
  endfunction

  function automatic logic signed [32:0] to_signed(input sm_t a);
    return a.sg ? -$signed({2'b00, a.mag}) : $signed({2'b00, a.mag});
  endfunction

  function automatic logic [OUT_W-1:0] out_round(input logic signed [32:0] v);
    logic        neg;
    logic [32:0] u;
    logic [32:0] r;
    neg = v[32];
    u = neg ? 33'(-v) : 33'(v);
    u = (u + OUT_HALF) >> OUT_SHIFT;
    if (u > OUT_LIM) u = OUT_LIM;
    r = neg ? -u : u;
    return r[OUT_W-1:0];
  endfunction

  // Clamp a series sum to [0, 1] in Q2.30.
  function automatic logic [30:0] clamp_unit(input logic signed [SUM_W-1:0] v);
    if (v < 0) return 31'd0;
    if (v > $signed(SUM_W'(ONE_Q30))) return ONE_Q30;
    return v[30:0];
  endfunction

  logic                   v0_q, v1_q, v2_q, v3_q, v4_q;
  sm_t                    s0_q [NUM_LANES];
  sm_t                    c0_q [NUM_LANES];
  sm_t                    t1_q, a1_q, sr1_q, cr1_q, sp1_q;
  sm_t                    pr1_q [NUM_PAIRS];
  sm_t                    tsr2_q, tcr2_q, asr2_q, acr2_q, sp2_q;
  sm_t                    pr2_q [NUM_PAIRS];
  logic signed [32:0]     e3_q [NUM_ELEMS];
  out_item_t              item_q;

  sm_t                    s0_d [NUM_LANES];
  sm_t                    c0_d [NUM_LANES];
  sm_t                    pr1_d [NUM_PAIRS];
  logic signed [32:0]     e3_d [NUM_ELEMS];
  out_item_t              item_d;

  // Stage 0: clamp the series and unfold the octant into the full angle.
  always_comb begin
    logic [30:0] so;
    logic [30:0] co;
    for (int i = 0; i < NUM_LANES; i++) begin
      so = clamp_unit(chain_i.lane[i].s_sum);
      co = clamp_unit(chain_i.lane[i].c_sum);
      s0_d[i].mag = chain_i.lane[i].fold.swap ? co : so;
      s0_d[i].sg  = chain_i.lane[i].fold.sneg;
      c0_d[i].mag = chain_i.lane[i].fold.swap ? so : co;
      c0_d[i].sg  = chain_i.lane[i].fold.cneg;
    end
  end

  // Stage 1: products of two factors.
  always_comb begin
    pr1_d[P_CYCR] = qmul(c0_q[LANE_YAW],   c0_q[LANE_ROLL]);
    pr1_d[P_CPSR] = qmul(c0_q[LANE_PITCH], s0_q[LANE_ROLL]);
    pr1_d[P_SYCR] = qmul(s0_q[LANE_YAW],   c0_q[LANE_ROLL]);
    pr1_d[P_CYSR] = qmul(c0_q[LANE_YAW],   s0_q[LANE_ROLL]);
    pr1_d[P_CPCR] = qmul(c0_q[LANE_PITCH], c0_q[LANE_ROLL]);
    pr1_d[P_SYSR] = qmul(s0_q[LANE_YAW],   s0_q[LANE_ROLL]);
    pr1_d[P_SYCP] = qmul(s0_q[LANE_YAW],   c0_q[LANE_PITCH]);
    pr1_d[P_CYCP] = qmul(c0_q[LANE_YAW],   c0_q[LANE_PITCH]);
  end

  // Stage 3: sum the terms of each element.
  always_comb begin
    e3_d[0] = to_signed(pr2_q[P_CYCR]) + to_signed(tsr2_q);
    e3_d[1] = to_signed(pr2_q[P_CPSR]);
    e3_d[2] = to_signed(asr2_q) - to_signed(pr2_q[P_SYCR]);
    e3_d[3] = to_signed(tcr2_q) - to_signed(pr2_q[P_CYSR]);
    e3_d[4] = to_signed(pr2_q[P_CPCR]);
    e3_d[5] = to_signed(pr2_q[P_SYSR]) + to_signed(acr2_q);
    e3_d[6] = to_signed(pr2_q[P_SYCP]);
    e3_d[7] = -to_signed(sp2_q);
    e3_d[8] = to_signed(pr2_q[P_CYCP]);
  end

  // Stage 4: round each element to the output format.
  always_comb begin
    item_d.m00 = out_round(e3_q[0]);
    item_d.m01 = out_round(e3_q[1]);
    item_d.m02 = out_round(e3_q[2]);
    item_d.m10 = out_round(e3_q[3]);
    item_d.m11 = out_round(e3_q[4]);
    item_d.m12 = out_round(e3_q[5]);
    item_d.m20 = out_round(e3_q[6]);
    item_d.m21 = out_round(e3_q[7]);
    item_d.m22 = out_round(e3_q[8]);
  end

  // Valid bits of the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= chain_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage payloads; stage 2 forms the three-factor products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        s0_q[i] <= s0_d[i];
        c0_q[i] <= c0_d[i];
      end
      t1_q  <= qmul(s0_q[LANE_YAW], s0_q[LANE_PITCH]);
      a1_q  <= qmul(c0_q[LANE_YAW], s0_q[LANE_PITCH]);
      sr1_q <= s0_q[LANE_ROLL];
      cr1_q <= c0_q[LANE_ROLL];
      sp1_q <= s0_q[LANE_PITCH];
      for (int k = 0; k < NUM_PAIRS; k++) begin
        pr1_q[k] <= pr1_d[k];
        pr2_q[k] <= pr1_q[k];
      end
      tsr2_q <= qmul(t1_q, sr1_q);
      tcr2_q <= qmul(t1_q, cr1_q);
      asr2_q <= qmul(a1_q, sr1_q);
      acr2_q <= qmul(a1_q, cr1_q);
      sp2_q  <= sp1_q;
      for (int k = 0; k < NUM_ELEMS; k++) begin
        e3_q[k] <= e3_d[k];
      end
      item_q <= item_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[rtl/euler_to_rotation_matrix_core.sv]
`default_nettype none

`include "euler_to_rotation_matrix_core_macros.svh"

// Euler angles to rotation matrix, YXZ order, transposed result. Each item
// carries pitch, yaw and roll in signed degrees with 7 fraction bits, clamped
// to plus or minus 180 degrees, and yields the nine row-major Q1.14 elements
// of the transpose of Ry(yaw) * Rx(pitch) * Rz(roll). The block is a fully
// pipelined datapath: three front stages convert the angles to radians, a
// chain of six series cells (three stages each) builds sine and cosine by
// Taylor terms, and five stages form and round the matrix products. It takes
// one item per clock while in_stall_o is low. A one-item skid buffer behind
// the output register lets the pipeline keep accepting while one result
// waits; in_stall_o is high only while that buffer is full.
module euler_to_rotation_matrix_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  e2r_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output e2r_pkg::out_item_t   out_item_o
);
  import e2r_pkg::*;

  logic      en;
  logic      end_valid;
  out_item_t end_item;
  chain_t    chain [NUM_CELLS+1];

  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;
  logic      take;

  // The whole pipeline moves while the skid buffer is empty.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  e2r_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .chain_o    (chain[0])
  );

  // Series cells; even cells subtract their terms.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam cell_cfg_t CFG = '{
      neg:       1'((k % 2) == 0),
      sin_act:   1'(SIN_DIV[k] != 8'd0),
      sin_div:   SIN_DIV[k],
      sin_recip: SIN_RECIP[k],
      cos_div:   COS_DIV[k],
      cos_recip: COS_RECIP[k]
    };
    e2r_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cfg_i   (CFG),
      .chain_i (chain[k]),
      .chain_o (chain[k+1])
    );
  end

  e2r_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .chain_i (chain[NUM_CELLS]),
    .valid_o (end_valid),
    .item_o  (end_item)
  );

  assign take = out_valid_q && !out_stall_i;

  // Output register with a one-item skid buffer behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (end_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (end_valid) begin
      if (out_valid_q && !take) begin
        skid_q <= end_item;
      end else begin
        out_q <= end_item;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `E2R_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `E2R_ASSERT_NEXT(a_skid_drains, take && skid_valid_q, out_valid_q && !skid_valid_q)
  `E2R_ASSERT_NEXT(a_skid_fills, out_valid_q && out_stall_i && !skid_valid_q && end_valid, skid_valid_q)
  `E2R_ASSERT_NEXT(a_skid_holds, skid_valid_q && out_stall_i, skid_valid_q && $stable(skid_q))

endmodule

`default_nettype wire
